FILE: rtl/obbsat_pkg.sv
// shared constants and types for the oriented box separating axis test
// no dependencies; imported by obbsat_dot and obb_overlap_separating_axis_2d
`default_nettype none

package obbsat_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    localparam int AXIS_CODE_WIDTH = 3;
    localparam int NUM_AXES        = 4;

    // candidate axes in test order, plus the "no separating axis" code
    localparam logic [AXIS_CODE_WIDTH-1:0] AXIS_LEFT_A  = 3'd0;
    localparam logic [AXIS_CODE_WIDTH-1:0] AXIS_LEFT_B  = 3'd1;
    localparam logic [AXIS_CODE_WIDTH-1:0] AXIS_RIGHT_A = 3'd2;
    localparam logic [AXIS_CODE_WIDTH-1:0] AXIS_RIGHT_B = 3'd3;
    localparam logic [AXIS_CODE_WIDTH-1:0] AXIS_NONE    = 3'd4;

    // load enables for the stages inside a dot product lane
    typedef struct packed {
        logic prod;
        logic dot;
        logic mag;
    } adv_t;

endpackage

`default_nettype wire

FILE: rtl/obb_overlap_separating_axis_2d.sv
// separating axis overlap test for two oriented rectangles, six-stage pipeline
// depends on obbsat_pkg and obbsat_dot
//
// usage:
//   pair channel: pair_valid/pair_stall carry one beat per box pair: center and
//   both full edge vectors of each box, signed Q16.8 at COORD_WIDTH bits
//   result channel: result_valid/result_stall carry overlap and
//   separating_axis (0..3 = first separating edge in the order left a,
//   left b, right a, right b; 4 = none, overlap set)
//   throughput: one pair per cycle unless result_stall holds the pipe, set by
//   the fully pipelined multiplier lanes
//   pipeline: the accepting edge loads the first of six stages (capture and
//   center difference, products, dot sums, magnitudes, axis sums, compare)
//   stall: each stage advances whenever the one after it is empty or moving,
//   so bubbles close up; pair_stall rises only when all six stages hold beats
//   and result_stall is high; nothing is dropped or repeated
//   reset: clears all stage valid bits; the pipeline is empty after reset
`default_nettype none

module obb_overlap_separating_axis_2d #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pair_valid,
    output logic                               pair_stall,
    input  wire logic signed [COORD_WIDTH-1:0] left_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] left_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] left_edge_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] left_edge_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] left_edge_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] left_edge_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] right_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] right_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] right_edge_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] right_edge_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] right_edge_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] right_edge_b_y,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               overlap,
    output logic [obbsat_pkg::AXIS_CODE_WIDTH-1:0] separating_axis
);
    import obbsat_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int CW  = W + 1;        // center difference
    localparam int EMW = 2 * W;        // |edge . edge|
    localparam int CMW = 2 * W + 1;    // |center . edge|
    localparam int SW  = 2 * W + 2;    // axis sum and doubled center term

    // stage valid bits and ready chain
    logic s1_valid_reg, s1_valid_next, s1_ready;
    logic s2_valid_reg, s2_valid_next, s2_ready;
    logic s3_valid_reg, s3_valid_next, s3_ready;
    logic s4_valid_reg, s4_valid_next, s4_ready;
    logic s5_valid_reg, s5_valid_next, s5_ready;
    logic s6_valid_reg, s6_valid_next, s6_ready;

    assign s6_ready = !s6_valid_reg || !result_stall;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign pair_stall = !s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? pair_valid   : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
        s5_valid_next = s5_ready ? s4_valid_reg : s5_valid_reg;
        s6_valid_next = s6_ready ? s5_valid_reg : s6_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
            s6_valid_reg <= s6_valid_next;
        end
    end

    // stage 1: capture edges, center difference
    logic signed [W-1:0]  ex_reg [NUM_AXES];
    logic signed [W-1:0]  ey_reg [NUM_AXES];
    logic signed [W-1:0]  ex_next [NUM_AXES];
    logic signed [W-1:0]  ey_next [NUM_AXES];
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;

    always_comb
    begin
        ex_next[0] = left_edge_a_x;
        ey_next[0] = left_edge_a_y;
        ex_next[1] = left_edge_b_x;
        ey_next[1] = left_edge_b_y;
        ex_next[2] = right_edge_a_x;
        ey_next[2] = right_edge_a_y;
        ex_next[3] = right_edge_b_x;
        ey_next[3] = right_edge_b_y;
        cx_next = {left_center_x[W-1], left_center_x} - {right_center_x[W-1], right_center_x};
        cy_next = {left_center_y[W-1], left_center_y} - {right_center_y[W-1], right_center_y};
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                ex_reg[k] <= ex_next[k];
                ey_reg[k] <= ey_next[k];
            end
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    // stages 2..4 live in the dot product lanes
    adv_t lane_ctl;
    assign lane_ctl.prod = s2_ready;
    assign lane_ctl.dot  = s3_ready;
    assign lane_ctl.mag  = s4_ready;

    logic [EMW-1:0] emag [NUM_AXES][NUM_AXES];
    logic [CMW-1:0] cmag [NUM_AXES];

    // edge-edge dots are symmetric: only the upper triangle gets a lane
    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_row
        for (genvar j = 0; j < NUM_AXES; j++)
        begin : g_col
            if (j >= i)
            begin : g_lane
                obbsat_dot #(
                    .A_WIDTH(W),
                    .B_WIDTH(W)
                ) u_edge_dot (
                    .clk (clk),
                    .ctl (lane_ctl),
                    .ux  (ex_reg[j]),
                    .uy  (ey_reg[j]),
                    .vx  (ex_reg[i]),
                    .vy  (ey_reg[i]),
                    .mag (emag[i][j])
                );
            end
            else
            begin : g_mirror
                assign emag[i][j] = emag[j][i];
            end
        end

        obbsat_dot #(
            .A_WIDTH(CW),
            .B_WIDTH(W)
        ) u_center_dot (
            .clk (clk),
            .ctl (lane_ctl),
            .ux  (cx_reg),
            .uy  (cy_reg),
            .vx  (ex_reg[i]),
            .vy  (ey_reg[i]),
            .mag (cmag[i])
        );
    end

    // stage 5: per-axis projection sum and doubled center term
    logic [SW-1:0] sum_reg [NUM_AXES];
    logic [SW-1:0] sum_next [NUM_AXES];
    logic [SW-1:0] ctr_reg [NUM_AXES];
    logic [SW-1:0] ctr_next [NUM_AXES];

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_next[a] = ({2'b00, emag[a][0]} + {2'b00, emag[a][1]})
                        + ({2'b00, emag[a][2]} + {2'b00, emag[a][3]});
            ctr_next[a] = {cmag[a], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
                ctr_reg[a] <= ctr_next[a];
            end
        end
    end

    // stage 6: compare and pick the first separating axis
    logic [NUM_AXES-1:0]        sep;
    logic [AXIS_CODE_WIDTH-1:0] axis_reg, axis_next;
    logic                       overlap_reg, overlap_next;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sep[a] = sum_reg[a] < ctr_reg[a];
        end
        axis_next = AXIS_NONE;
        if (sep[3])
        begin
            axis_next = AXIS_RIGHT_B;
        end
        if (sep[2])
        begin
            axis_next = AXIS_RIGHT_A;
        end
        if (sep[1])
        begin
            axis_next = AXIS_LEFT_B;
        end
        if (sep[0])
        begin
            axis_next = AXIS_LEFT_A;
        end
        overlap_next = (sep == '0);
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready)
        begin
            axis_reg    <= axis_next;
            overlap_reg <= overlap_next;
        end
    end

    assign result_valid    = s6_valid_reg;
    assign overlap         = overlap_reg;
    assign separating_axis = axis_reg;

`ifndef NO_ASSERTIONS
    // overlap flag and axis code always agree
    a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (overlap == (separating_axis == AXIS_NONE)))
        else $error("overlap flag disagrees with axis code");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (separating_axis <= AXIS_NONE))
        else $error("axis code out of range");

    // a beat in stage 5 moving forward must show up at the output
    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && s6_ready) |=> result_valid)
        else $error("beat lost leaving stage 5");

    // input is held off only when the whole pipe is full and blocked
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                        && s5_valid_reg && s6_valid_reg && result_stall))
        else $error("input stalled with room in the pipe");
`endif

endmodule

`default_nettype wire

FILE: rtl/obbsat_dot.sv
// three-stage dot product lane: products, sum, absolute value
// depends on obbsat_pkg for the stage enable struct
`default_nettype none

module obbsat_dot #(
    parameter int A_WIDTH = 25,
    parameter int B_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire obbsat_pkg::adv_t               ctl,
    input  wire logic signed [A_WIDTH-1:0]      ux,
    input  wire logic signed [A_WIDTH-1:0]      uy,
    input  wire logic signed [B_WIDTH-1:0]      vx,
    input  wire logic signed [B_WIDTH-1:0]      vy,
    output logic             [A_WIDTH+B_WIDTH-1:0] mag
);
    import obbsat_pkg::*;

    localparam int P_WIDTH = A_WIDTH + B_WIDTH;
    localparam int D_WIDTH = P_WIDTH + 1;

    logic signed [P_WIDTH-1:0] px_reg, px_next;
    logic signed [P_WIDTH-1:0] py_reg, py_next;
    logic signed [D_WIDTH-1:0] dot_reg, dot_next;
    logic        [D_WIDTH-1:0] dot_neg;
    logic        [P_WIDTH-1:0] mag_reg, mag_next;

    always_comb
    begin
        px_next  = P_WIDTH'(ux) * P_WIDTH'(vx);
        py_next  = P_WIDTH'(uy) * P_WIDTH'(vy);
        dot_next = {px_reg[P_WIDTH-1], px_reg} + {py_reg[P_WIDTH-1], py_reg};
        dot_neg  = -dot_reg;
        // magnitude never exceeds the product width, so the top bit drops
        mag_next = dot_reg[D_WIDTH-1] ? dot_neg[P_WIDTH-1:0] : dot_reg[P_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prod)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (ctl.dot)
        begin
            dot_reg <= dot_next;
        end
        if (ctl.mag)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

`default_nettype wire
